// ===== hdl/rpn_proposal_box_decode_core_macros.svh =====
// Assertion shorthands for the proposal box decoder.
// Every property is sampled on clk and switched off while rst is high.
`ifndef RPN_PROPOSAL_BOX_DECODE_CORE_MACROS_SVH
`define RPN_PROPOSAL_BOX_DECODE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPNBD_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPNBD_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rpnbd_pkg.sv =====
package rpnbd_pkg;

  // Configuration port geometry.
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // Register widths and reset values.
  localparam int STRIDE_W = 7;
  localparam int DIM_W    = 13;
  localparam int MIN_W    = 11;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 7'd16;
  localparam logic [DIM_W-1:0]    IMG_W_RESET  = 13'd1000;
  localparam logic [DIM_W-1:0]    IMG_H_RESET  = 13'd600;
  localparam logic [MIN_W-1:0]    MIN_RESET    = 11'd16;

  // Grid cell index times stride.
  localparam int GRID_W = 17;

  // Exp table entries are unsigned Q32 values below 2^45.
  localparam int EXP_W = 45;

  localparam logic [63:0] EXP_NEG8_Q32 = 64'd1440801;

  // exp(2^(j-12)) in Q20, one entry per bit of the table position.
  localparam logic [63:0] EXP_BIT_Q20 [16] = '{
    64'd1048832, 64'd1049088, 64'd1049601, 64'd1050626,
    64'd1052680, 64'd1056800, 64'd1065089, 64'd1081861,
    64'd1116203, 64'd1188192, 64'd1346398, 64'd1728810,
    64'd2850325, 64'd7747987, 64'd57250310, 64'd3125761002
  };

  typedef enum logic [1:0] {
    REG_STRIDE   = 2'd0,
    REG_IMG_W    = 2'd1,
    REG_IMG_H    = 2'd2,
    REG_MIN_SIZE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        [9:0]  grid_col;
    logic        [9:0]  grid_row;
    logic signed [15:0] anchor_left;
    logic signed [15:0] anchor_top;
    logic signed [15:0] anchor_right;
    logic signed [15:0] anchor_bottom;
    logic signed [15:0] shift_x;
    logic signed [15:0] shift_y;
    logic signed [15:0] log_scale_w;
    logic signed [15:0] log_scale_h;
    logic        [15:0] fg_score;
  } item_t;

  typedef struct packed {
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_right;
    logic [15:0] box_bottom;
    logic [15:0] masked_score;
    logic        kept;
  } box_t;

  // Builds one exp table value from its Q4.12 position above -8, lowest
  // bit first, rounding each product back to Q32. Used at elaboration only.
  function automatic logic [63:0] exp_table_entry(input logic [15:0] u);
    logic [63:0] r;
    r = EXP_NEG8_Q32;
    for (int j = 0; j < 16; j++) begin
      if (u[j]) begin
        r = (r * EXP_BIT_Q20[j] + 64'd524288) >> 20;
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/rpn_proposal_box_decode_core.sv =====
// Channel     | Direction | Handshake                    | Payload
// ------------+-----------+------------------------------+----------------------------
// item        | in        | item_valid / item_stall      | item_t: anchor, cell, deltas
// box         | out       | box_valid / box_stall        | box_t: clipped box, score
// config      | in        | psel, penable, pwrite, pready| 32-bit registers at 4*index
//
// One request enters per cycle while item_stall is low, and its box leaves through
// the six register stages; the exp table read has a stage of its own, and the two
// products per axis share the stage after it.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults.
// A stall on the box side holds only the stages that are full, so bubbles close
// up and requests are still taken until every stage holds a request.
//
// Data path per axis, one stage each:
//   1: cell times stride, exp table index from the log scale delta.
//   2: exp table read, absolute low corner and anchor size.
//   3: doubled center, delta times size, exp value times size.
//   4: center sum and rounded half size.
//   5: round back to coordinate format and clip to the image.
//   6: minimum size test and score masking into the output register.
module rpn_proposal_box_decode_core
  import rpnbd_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 4,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  item_t             item,
  input  logic              item_valid,
  output logic              item_stall,
  output box_t              box,
  output logic              box_valid,
  input  logic              box_stall
);

  localparam int F        = COORD_FRAC_BITS;
  localparam int ONE      = 1 << F;
  localparam int IDX_W    = $clog2(EXP_TABLE_DEPTH);
  localparam int NSTAGE   = 6;
  // Absolute corner: cell offset plus anchor.
  localparam int X_W      = F + 19;
  // Anchor size: corner difference plus one pixel.
  localparam int SIZE_W   = 18;
  // (2*x1 + size) * 4096.
  localparam int POS_W    = F + 33;
  // Delta times size.
  localparam int DXP_W    = 34;
  // Exp value times size.
  localparam int EP_W     = EXP_W + 1 + SIZE_W;
  localparam int C_W      = F + 36;
  localparam int HALF_W   = EP_W - 20;
  localparam int SUM_W    = ((C_W > HALF_W) ? C_W : HALF_W) + 1;
  localparam int RND_W    = SUM_W - 13;
  localparam int LIM_W    = 18;
  localparam int LIMRAW_W = 18 + F;
  localparam int KW       = ((F + 12) > 18) ? (F + 12) : 18;

  // ---------------------------------------------------------------------------
  // Configuration registers. User writes only while the pipeline is idle; unchecked.
  // ---------------------------------------------------------------------------
  logic [STRIDE_W-1:0] stride;
  logic [DIM_W-1:0]    img_w;
  logic [DIM_W-1:0]    img_h;
  logic [MIN_W-1:0]    min_size;
  cfg_reg_t            cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      stride   <= STRIDE_RESET;
      img_w    <= IMG_W_RESET;
      img_h    <= IMG_H_RESET;
      min_size <= MIN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (cfg_sel)
        REG_STRIDE:   stride   <= pwdata[STRIDE_W-1:0];
        REG_IMG_W:    img_w    <= pwdata[DIM_W-1:0];
        REG_IMG_H:    img_h    <= pwdata[DIM_W-1:0];
        REG_MIN_SIZE: min_size <= pwdata[MIN_W-1:0];
        default:      stride   <= stride;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      REG_STRIDE:   prdata = DATA_W'(stride);
      REG_IMG_W:    prdata = DATA_W'(img_w);
      REG_IMG_H:    prdata = DATA_W'(img_h);
      REG_MIN_SIZE: prdata = DATA_W'(min_size);
      default:      prdata = '0;
    endcase
  end

  // The clip limit is (dimension - 1) pixels, saturated to the 16-bit output.
  // A zero dimension gives a negative limit, which clips every corner to zero.
  logic signed [LIMRAW_W-1:0] lim_x_raw;
  logic signed [LIMRAW_W-1:0] lim_y_raw;
  logic signed [LIM_W-1:0]    lim_x;
  logic signed [LIM_W-1:0]    lim_y;
  logic signed [KW-1:0]       min_fx;

  always_comb begin
    lim_x_raw = (LIMRAW_W'($signed({1'b0, img_w})) - LIMRAW_W'(1)) <<< F;
    lim_y_raw = (LIMRAW_W'($signed({1'b0, img_h})) - LIMRAW_W'(1)) <<< F;
    lim_x = (lim_x_raw > LIMRAW_W'(65535)) ? LIM_W'(65535) : LIM_W'(lim_x_raw);
    lim_y = (lim_y_raw > LIMRAW_W'(65535)) ? LIM_W'(65535) : LIM_W'(lim_y_raw);
    min_fx = $signed(KW'(min_size) << F);
  end

  // ---------------------------------------------------------------------------
  // Exp table. Entry i holds exp(-8 + u/4096) in Q32, u = i * 65536 / depth.
  // ---------------------------------------------------------------------------
  logic [EXP_W-1:0] exp_rom [EXP_TABLE_DEPTH];

  for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_rom
    localparam longint unsigned U = (longint'(gi) * 65536) / EXP_TABLE_DEPTH;
    assign exp_rom[gi] = EXP_W'(exp_table_entry(16'(U)));
  end

  // A delta reads the table point at or below it.
  function automatic logic [IDX_W-1:0] exp_index(input logic [15:0] d);
    logic [31:0] prod;
    prod = 32'({~d[15], d[14:0]}) * 32'(EXP_TABLE_DEPTH);
    return prod[IDX_W+15:16];
  endfunction

  // Clamp to the limit first, then to zero, so a negative limit gives zero.
  function automatic logic [15:0] clip_coord(input logic signed [RND_W-1:0] v,
                                             input logic signed [LIM_W-1:0] lim);
    logic signed [RND_W-1:0] t;
    t = (v > RND_W'(lim)) ? RND_W'(lim) : v;
    return (t < 0) ? 16'd0 : t[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Pipeline control. A stage loads when it is empty or the stage after it
  // moves on; the last stage is the output register.
  // ---------------------------------------------------------------------------
  logic [NSTAGE-1:0] stage_valid;
  logic [NSTAGE-1:0] stage_valid_next;
  logic [NSTAGE-1:0] stage_en;

  always_comb begin
    stage_en[NSTAGE-1] = !stage_valid[NSTAGE-1] || !box_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      stage_en[k] = !stage_valid[k] || stage_en[k+1];
    end
    stage_valid_next[0] = stage_en[0] ? item_valid : stage_valid[0];
    for (int k = 1; k < NSTAGE; k++) begin
      if (stage_en[k]) begin
        stage_valid_next[k] = stage_valid[k-1];
      end else begin
        stage_valid_next[k] = stage_valid[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  assign item_stall = !stage_en[0];
  assign box_valid  = stage_valid[NSTAGE-1];

  // Stage 1: cell offsets in pixels and exp table addresses.
  logic [GRID_W-1:0] s1_sx;
  logic [GRID_W-1:0] s1_sy;
  logic [IDX_W-1:0]  s1_idx_w;
  logic [IDX_W-1:0]  s1_idx_h;
  item_t             s1_item;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      s1_sx    <= GRID_W'(item.grid_col) * GRID_W'(stride);
      s1_sy    <= GRID_W'(item.grid_row) * GRID_W'(stride);
      s1_idx_w <= exp_index(item.log_scale_w);
      s1_idx_h <= exp_index(item.log_scale_h);
      s1_item  <= item;
    end
  end

  // Stage 2: table read, absolute low corners and anchor sizes.
  logic [EXP_W-1:0]         s2_exp_w;
  logic [EXP_W-1:0]         s2_exp_h;
  logic signed [X_W-1:0]    s2_x1;
  logic signed [X_W-1:0]    s2_y1;
  logic signed [SIZE_W-1:0] s2_size_x;
  logic signed [SIZE_W-1:0] s2_size_y;
  logic signed [15:0]       s2_shift_x;
  logic signed [15:0]       s2_shift_y;
  logic [15:0]              s2_score;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s2_exp_w   <= exp_rom[s1_idx_w];
      s2_exp_h   <= exp_rom[s1_idx_h];
      s2_x1      <= $signed(X_W'(s1_sx) << F) + X_W'(s1_item.anchor_left);
      s2_y1      <= $signed(X_W'(s1_sy) << F) + X_W'(s1_item.anchor_top);
      s2_size_x  <= SIZE_W'(s1_item.anchor_right) - SIZE_W'(s1_item.anchor_left)
                    + SIZE_W'(ONE);
      s2_size_y  <= SIZE_W'(s1_item.anchor_bottom) - SIZE_W'(s1_item.anchor_top)
                    + SIZE_W'(ONE);
      s2_shift_x <= s1_item.shift_x;
      s2_shift_y <= s1_item.shift_y;
      s2_score   <= s1_item.fg_score;
    end
  end

  // Stage 3: the two products per axis and the doubled center in Q.13 steps.
  logic signed [POS_W-1:0] s3_pos_x;
  logic signed [POS_W-1:0] s3_pos_y;
  logic signed [DXP_W-1:0] s3_dxp_x;
  logic signed [DXP_W-1:0] s3_dxp_y;
  logic signed [EP_W-1:0]  s3_ep_x;
  logic signed [EP_W-1:0]  s3_ep_y;
  logic [15:0]             s3_score;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      s3_pos_x <= (POS_W'(s2_x1) <<< 13) + (POS_W'(s2_size_x) <<< 12);
      s3_pos_y <= (POS_W'(s2_y1) <<< 13) + (POS_W'(s2_size_y) <<< 12);
      s3_dxp_x <= s2_shift_x * s2_size_x;
      s3_dxp_y <= s2_shift_y * s2_size_y;
      s3_ep_x  <= $signed({1'b0, s2_exp_w}) * s2_size_x;
      s3_ep_y  <= $signed({1'b0, s2_exp_h}) * s2_size_y;
      s3_score <= s2_score;
    end
  end

  // Stage 4: center and half size, the latter rounded half up from Q32.
  logic signed [C_W-1:0]    s4_c_x;
  logic signed [C_W-1:0]    s4_c_y;
  logic signed [HALF_W-1:0] s4_half_x;
  logic signed [HALF_W-1:0] s4_half_y;
  logic [15:0]              s4_score;

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      s4_c_x    <= C_W'(s3_pos_x) + (C_W'(s3_dxp_x) <<< 1);
      s4_c_y    <= C_W'(s3_pos_y) + (C_W'(s3_dxp_y) <<< 1);
      s4_half_x <= HALF_W'((s3_ep_x + EP_W'(1 << 19)) >>> 20);
      s4_half_y <= HALF_W'((s3_ep_y + EP_W'(1 << 19)) >>> 20);
      s4_score  <= s3_score;
    end
  end

  // Stage 5: new corners rounded half up to coordinate format, then clipped.
  logic signed [SUM_W-1:0] x1_sum;
  logic signed [SUM_W-1:0] x2_sum;
  logic signed [SUM_W-1:0] y1_sum;
  logic signed [SUM_W-1:0] y2_sum;

  always_comb begin
    x1_sum = SUM_W'(s4_c_x) - SUM_W'(s4_half_x) + SUM_W'(4096);
    x2_sum = SUM_W'(s4_c_x) + SUM_W'(s4_half_x) + SUM_W'(4096);
    y1_sum = SUM_W'(s4_c_y) - SUM_W'(s4_half_y) + SUM_W'(4096);
    y2_sum = SUM_W'(s4_c_y) + SUM_W'(s4_half_y) + SUM_W'(4096);
  end

  logic [15:0] s5_x1;
  logic [15:0] s5_x2;
  logic [15:0] s5_y1;
  logic [15:0] s5_y2;
  logic [15:0] s5_score;

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      s5_x1    <= clip_coord(RND_W'(x1_sum >>> 13), lim_x);
      s5_x2    <= clip_coord(RND_W'(x2_sum >>> 13), lim_x);
      s5_y1    <= clip_coord(RND_W'(y1_sum >>> 13), lim_y);
      s5_y2    <= clip_coord(RND_W'(y2_sum >>> 13), lim_y);
      s5_score <= s4_score;
    end
  end

  // Stage 6: minimum size test on the clipped box, into the output register.
  logic signed [KW-1:0] w_fx;
  logic signed [KW-1:0] h_fx;
  logic                 keep;

  always_comb begin
    w_fx = $signed(KW'(s5_x2)) - $signed(KW'(s5_x1)) + KW'(ONE);
    h_fx = $signed(KW'(s5_y2)) - $signed(KW'(s5_y1)) + KW'(ONE);
    keep = (w_fx >= min_fx) && (h_fx >= min_fx);
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      box.box_left     <= s5_x1;
      box.box_top      <= s5_y1;
      box.box_right    <= s5_x2;
      box.box_bottom   <= s5_y2;
      box.masked_score <= keep ? s5_score : 16'd0;
      box.kept         <= keep;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
`include "rpn_proposal_box_decode_core_macros.svh"

  `RPNBD_HOLDS(a_drop_zeroes_score, box_valid && !box.kept,
               box.masked_score == 16'd0, "dropped box carries a score")
  `RPNBD_HOLDS(a_stall_only_full, item_stall, &stage_valid,
               "request stalled with a free stage")
  `RPNBD_NEXT(a_request_kept, item_valid && !item_stall && !(box_valid && !box_stall),
              $countones(stage_valid) == $past($countones(stage_valid)) + 1,
              "accepted request lost")

endmodule

// ===== tb/box_decode_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, box and register ports of the proposal box decoder,
// predicts every box and compares it with what the decoder returns.
module box_decode_checker
  import rpnbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  item_t             item,
  input  logic              item_valid,
  input  logic              item_stall,
  input  box_t              box,
  input  logic              box_valid,
  input  logic              box_stall,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                mismatch_count,
  output int                boxes_in_flight
);

  localparam int     FRAC      = 4;
  localparam longint ONE       = longint'(1) << FRAC;
  localparam int     EXP_DEPTH = 1024;

  logic [STRIDE_W-1:0] stride_cfg;
  logic [DIM_W-1:0]    width_cfg;
  logic [DIM_W-1:0]    height_cfg;
  logic [MIN_W-1:0]    min_size_cfg;

  box_t expected_boxes[$];

  // exp(delta) in Q32; the delta is truncated down to the nearest table point.
  function automatic logic [63:0] exp_q32(input logic [15:0] delta);
    logic [63:0] code;
    logic [63:0] idx;
    logic [63:0] pos;
    logic [63:0] r;
    code = {48'd0, delta ^ 16'h8000};
    idx  = (code * 64'(EXP_DEPTH)) >> 16;
    pos  = ((idx << 16) / 64'(EXP_DEPTH)) & 64'hFFFF;
    r    = EXP_NEG8_Q32;
    for (int j = 0; j < 16; j++) begin
      if (pos[j]) begin
        r = (r * EXP_BIT_Q20[j] + 64'd524288) >> 20;
      end
    end
    return r;
  endfunction

  function automatic longint clamp_to_image(input longint v, input longint lim);
    longint c;
    c = (v > lim) ? lim : v;
    return (c < 0) ? 0 : c;
  endfunction

  // Decodes one axis. Positions are in units of 2^-(FRAC+13) pixels until
  // they are rounded half up back to coordinate format.
  function automatic void decode_axis(input longint lo, input longint hi,
                                      input logic signed [15:0] shift,
                                      input logic [15:0] log_scale,
                                      input logic [DIM_W-1:0] dim,
                                      output longint out_lo, output longint out_hi);
    longint size;
    longint ctr;
    longint e;
    longint half;
    longint lim;
    size = hi - lo + ONE;
    ctr  = (2 * lo + size) * 4096 + 2 * longint'(shift) * size;
    e    = longint'(exp_q32(log_scale));
    half = (e * size + (longint'(1) << 19)) >>> 20;
    lim  = (longint'(dim) - 1) * ONE;
    if (lim > 65535) begin
      lim = 65535;
    end
    out_lo = clamp_to_image((ctr - half + 4096) >>> 13, lim);
    out_hi = clamp_to_image((ctr + half + 4096) >>> 13, lim);
  endfunction

  function automatic box_t decode_box(input item_t it);
    longint sx;
    longint sy;
    longint x1;
    longint x2;
    longint y1;
    longint y2;
    longint min_fx;
    logic   keep;
    box_t   b;
    sx = longint'(it.grid_col) * longint'(stride_cfg) * ONE;
    sy = longint'(it.grid_row) * longint'(stride_cfg) * ONE;
    decode_axis(sx + longint'(it.anchor_left), sx + longint'(it.anchor_right),
                it.shift_x, it.log_scale_w, width_cfg, x1, x2);
    decode_axis(sy + longint'(it.anchor_top), sy + longint'(it.anchor_bottom),
                it.shift_y, it.log_scale_h, height_cfg, y1, y2);
    min_fx = longint'(min_size_cfg) * ONE;
    keep = (x2 - x1 + ONE >= min_fx) && (y2 - y1 + ONE >= min_fx);
    b.box_left     = 16'(x1);
    b.box_top      = 16'(y1);
    b.box_right    = 16'(x2);
    b.box_bottom   = 16'(y2);
    b.masked_score = keep ? it.fg_score : 16'd0;
    b.kept         = keep;
    return b;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    box_t want;
    if (rst) begin
      stride_cfg   = STRIDE_RESET;
      width_cfg    = IMG_W_RESET;
      height_cfg   = IMG_H_RESET;
      min_size_cfg = MIN_RESET;
      expected_boxes.delete();
    end else begin
      if (item_valid && !item_stall) begin
        expected_boxes.push_back(decode_box(item));
      end
      if (box_valid && !box_stall) begin
        if (expected_boxes.size() == 0) begin
          $error("box returned with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_boxes.pop_front();
          check_field("box_left", want.box_left, box.box_left);
          check_field("box_top", want.box_top, box.box_top);
          check_field("box_right", want.box_right, box.box_right);
          check_field("box_bottom", want.box_bottom, box.box_bottom);
          check_field("masked_score", want.masked_score, box.masked_score);
          check_field("kept", want.kept, box.kept);
        end
      end
      // Register writes only happen while the decoder is idle.
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[3:2]))
          REG_STRIDE:   stride_cfg   = pwdata[STRIDE_W-1:0];
          REG_IMG_W:    width_cfg    = pwdata[DIM_W-1:0];
          REG_IMG_H:    height_cfg   = pwdata[DIM_W-1:0];
          REG_MIN_SIZE: min_size_cfg = pwdata[MIN_W-1:0];
          default: ;
        endcase
      end
    end
    boxes_in_flight = expected_boxes.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Top of the proposal box decoder testbench. It produces the stimulus: the
// register settings, the requests and the stall pattern on the box side. All
// prediction and comparison live in the checker instantiated beside the
// decoder, which hands back its mismatch count and the number of boxes still
// owed.
module testbench;
  import rpnbd_pkg::*;

  // Cycles in a row with no request, box or register access before the run
  // is declared hung. The longest legal quiet stretch is the receiver hold-off.
  localparam int STUCK_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES          = 10;
  localparam int PHASE_ITEMS     = 145;

  logic              clk;
  logic              rst        = 1'b1;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [ADDR_W-1:0] paddr      = '0;
  logic [DATA_W-1:0] pwdata     = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  item_t             item       = '0;
  logic              item_valid = 1'b0;
  logic              item_stall;
  box_t              box;
  logic              box_valid;
  logic              box_stall  = 1'b0;

  int mismatch_count;
  int boxes_in_flight;

  // Sender and receiver pacing, changed from one phase to the next.
  int burst_left  = 1;
  bit gaps_on     = 1'b1;
  int rx_mode     = 0;
  bit hold_req    = 1'b0;

  // Settings for the fixed phases: the extremes first, including a zero
  // stride, zero image dimensions and dimensions above the clip saturation.
  int phase_stride[7] = '{1, 64, 0, 127, 16, 8, 16};
  int phase_width[7]  = '{4096, 1, 0, 8191, 1000, 640, 4097};
  int phase_height[7] = '{4096, 1, 0, 8191, 600, 480, 5000};
  int phase_min[7]    = '{0, 1024, 0, 2047, 16, 8, 1};

  rpn_proposal_box_decode_core dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .box        (box),
    .box_valid  (box_valid),
    .box_stall  (box_stall)
  );

  box_decode_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .item            (item),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .box             (box),
    .box_valid       (box_valid),
    .box_stall       (box_stall),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatch_count  (mismatch_count),
    .boxes_in_flight (boxes_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: any accepted request, box or register access restarts the count.
  initial begin
    int stuck_cycles;
    stuck_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (box_valid && !box_stall) ||
          (psel && penable)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Box side. A requested hold-off is taken once, wins over everything and
  // is counted down here, one cycle at a time. Otherwise the receiver either
  // never stalls, stalls at random about a quarter of the time, or follows an
  // on/off pattern whose period and duty change every time it wraps.
  initial begin
    int stall_pos;
    int stall_period;
    int stall_on;
    int hold_left;
    bit hold_taken;
    stall_pos    = 0;
    stall_period = 5;
    stall_on     = 2;
    hold_left    = 0;
    hold_taken   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_left  = HOLD_OFF_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        box_stall <= 1'b1;
        hold_left--;
      end else begin
        case (rx_mode)
          1: box_stall <= ($urandom_range(0, 3) == 0);
          2: begin
            box_stall <= (stall_pos < stall_on);
            stall_pos++;
            if (stall_pos >= stall_period) begin
              stall_pos    = 0;
              stall_period = $urandom_range(2, 9);
              stall_on     = $urandom_range(1, stall_period - 1);
            end
          end
          default: box_stall <= 1'b0;
        endcase
      end
    end
  end

  // One register write: setup cycle, then access until pready. The unused
  // upper data bits carry noise, which the register must ignore.
  task automatic write_register(input cfg_reg_t index, input int unsigned value,
                                input int field_bits);
    logic [DATA_W-1:0] data;
    data = $urandom;
    for (int b = 0; b < field_bits; b++) begin
      data[b] = value[b];
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stops offering requests and waits until every box owed has come back.
  task automatic drain_boxes();
    item_valid <= 1'b0;
    @(posedge clk);
    while (boxes_in_flight != 0) begin
      @(posedge clk);
    end
  endtask

  // Offers one request and holds it until it is taken. Requests go out in
  // bursts; when gaps are on, the sender drops valid after each burst.
  task automatic send_request(input item_t it);
    int gap;
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic item_t shaped_item(input int col, input int row,
                                        input int left, input int top,
                                        input int right, input int bottom,
                                        input int dx, input int dy,
                                        input int lw, input int lh,
                                        input int score);
    item_t it;
    it.grid_col      = 10'(col);
    it.grid_row      = 10'(row);
    it.anchor_left   = 16'(left);
    it.anchor_top    = 16'(top);
    it.anchor_right  = 16'(right);
    it.anchor_bottom = 16'(bottom);
    it.shift_x       = 16'(dx);
    it.shift_y       = 16'(dy);
    it.log_scale_w   = 16'(lw);
    it.log_scale_h   = 16'(lh);
    it.fg_score      = 16'(score);
    return it;
  endfunction

  // A plausible anchor near its cell with moderate deltas, so that most
  // boxes survive clipping and the size test. Now and then the cell index
  // is anywhere in its range or the anchor comes in inverted.
  function automatic item_t plausible_anchor();
    int cx;
    int cy;
    int hw;
    int hh;
    int col;
    int row;
    col = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 70);
    row = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 45);
    cx = int'($urandom_range(0, 512)) - 256;
    cy = int'($urandom_range(0, 512)) - 256;
    hw = $urandom_range(8, 4096);
    hh = $urandom_range(8, 4096);
    if ($urandom_range(0, 9) == 0) begin
      hw = -hw;
    end
    if ($urandom_range(0, 9) == 0) begin
      hh = -hh;
    end
    return shaped_item(col, row, cx - hw, cy - hh, cx + hw, cy + hh,
                       int'($urandom_range(0, 4096)) - 2048,
                       int'($urandom_range(0, 4096)) - 2048,
                       int'($urandom_range(0, 12288)) - 6144,
                       int'($urandom_range(0, 12288)) - 6144,
                       $urandom);
  endfunction

  // Every field fully random.
  function automatic item_t noise_item();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  initial begin
    int stride;
    int width;
    int height;
    int min_size;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests under the reset settings (stride 16, 1000 x 600,
    // minimum size 16).
    send_request(shaped_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(shaped_item(10, 5, -1024, -512, 1024, 512, 0, 0, 0, 0, 65535));
    // All fields at their largest value, then at their smallest.
    send_request(shaped_item(1023, 1023, 32767, 32767, 32767, 32767,
                             32767, 32767, 32767, 32767, 65535));
    send_request(shaped_item(0, 0, -32768, -32768, -32768, -32768,
                             -32768, -32768, -32768, -32768, 0));
    send_request(shaped_item(1023, 0, -32768, -32768, 32767, 32767,
                             32767, -32768, 32767, -32768, 12345));
    // Inverted anchor: negative width and height go straight into the math.
    send_request(shaped_item(20, 20, 800, 800, -800, -800, 0, 0, 0, 0, 4000));
    // Both ends of the exp table.
    send_request(shaped_item(3, 3, -128, -128, 128, 128, 0, 0, 32767, 32767, 1000));
    send_request(shaped_item(3, 3, -2048, -2048, 2048, 2048, 0, 0,
                             -32768, -32768, 1000));
    // Log deltas that fall between table points are truncated downward.
    send_request(shaped_item(7, 4, -512, -512, 512, 512, 0, 0, 33, -31, 2222));
    send_request(shaped_item(7, 4, -512, -512, 512, 512, 0, 0, 63, -1, 2223));
    // Too small to keep, and right at the minimum size.
    send_request(shaped_item(5, 5, -32, -32, 32, 32, 0, 0, 0, 0, 777));
    send_request(shaped_item(2, 2, 0, 0, 240, 240, 0, 0, 0, 0, 555));
    // Center shift extremes.
    send_request(shaped_item(30, 20, -512, -512, 512, 512, 32767, -32768, 0, 0, 9999));
    // Clipping at the top left, then at the bottom right.
    send_request(shaped_item(0, 0, -8000, -8000, 2000, 2000, 0, 0, 4096, 4096, 42));
    send_request(shaped_item(62, 37, -4000, -4000, 4000, 4000, 0, 0, 0, 0, 43));
    send_request(shaped_item(1, 1, -64, -256, 64, 256, 0, 0, 0, 0, 1));
    drain_boxes();

    for (int p = 0; p < PHASES; p++) begin
      // Phase 0 keeps the reset settings; every later phase rewrites all
      // four registers while the decoder is empty.
      if (p > 0) begin
        if (p <= 7) begin
          stride   = phase_stride[p-1];
          width    = phase_width[p-1];
          height   = phase_height[p-1];
          min_size = phase_min[p-1];
        end else begin
          stride   = $urandom_range(1, 64);
          width    = $urandom_range(1, 4096);
          height   = $urandom_range(1, 4096);
          min_size = $urandom_range(0, 64);
        end
        write_register(REG_STRIDE, stride, STRIDE_W);
        write_register(REG_IMG_W, width, DIM_W);
        write_register(REG_IMG_H, height, DIM_W);
        write_register(REG_MIN_SIZE, min_size, MIN_W);
      end

      // Phase 0 runs with no idling on either side; the others mix sender
      // gaps, off again in phases 4 and 8, with the three receiver behaviors.
      gaps_on = (p % 4 != 0);
      rx_mode = p % 3;

      // Once, the receiver holds off for a long stretch while requests keep
      // coming, so the pipeline fills and the decoder stalls its input.
      if (p == 2) begin
        hold_req = 1'b1;
      end

      repeat (PHASE_ITEMS) begin
        send_request(($urandom_range(0, 9) < 7) ? plausible_anchor() : noise_item());
      end
      drain_boxes();
    end

    // Let the six pipeline stages run empty, in case a stray box appears.
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && boxes_in_flight == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== rpn_proposal_box_decode_core.f =====
+incdir+hdl
hdl/rpnbd_pkg.sv
hdl/rpn_proposal_box_decode_core.sv
tb/box_decode_checker.sv
tb/testbench.sv
